>>> hdl/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned PosW      = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned DistW     = 14;
  localparam int unsigned DistHighW = DistW - ByteW;

  localparam logic [ByteW-1:0] HeaderByte = 8'hFA;
  localparam logic [ByteW-1:0] AngleBase  = 8'hA0;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // byte positions inside one packet, header is position zero
  localparam logic [PosW-1:0] PosHeader  = 5'd0;
  localparam logic [PosW-1:0] PosIndex   = 5'd1;
  localparam logic [PosW-1:0] PosSpeedLo = 5'd2;
  localparam logic [PosW-1:0] PosSpeedHi = 5'd3;
  localparam logic [PosW-1:0] PosDistALo = 5'd4;
  localparam logic [PosW-1:0] PosDistAHi = 5'd5;
  localparam logic [PosW-1:0] PosDistBLo = 5'd8;
  localparam logic [PosW-1:0] PosDistBHi = 5'd9;
  localparam logic [PosW-1:0] PosDistCLo = 5'd12;
  localparam logic [PosW-1:0] PosDistCHi = 5'd13;
  localparam logic [PosW-1:0] PosDistDLo = 5'd16;
  localparam logic [PosW-1:0] PosDistDHi = 5'd17;
  localparam logic [PosW-1:0] PosLast    = 5'd21;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] data;
  } beat_t;

endpackage

>>> hdl/lidar_packet_deframer_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake        beat
// -------   ---------  ---------------  -------------------------------------------
// input     in         push / full      rx_byte_i
// result    out        empty / pop      start_angle_o, rotation_speed_o, distance_*_o
//
// one byte accepted every cycle while full is low; bytes outside a packet are dropped
// a result shows once the last byte of its packet has left the beat queue and is registered in the result slot
// rst_ni is asynchronous, active low, and empties the queue and the result slot
// an unpopped result stalls only the last byte of the next packet; then the
// two-entry beat queue fills and full rises

module lidar_packet_deframer_core import lpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [AngleW-1:0] start_angle_o,
  output logic [SpeedW-1:0] rotation_speed_o,
  output logic [DistW-1:0]  distance_a_o,
  output logic [DistW-1:0]  distance_b_o,
  output logic [DistW-1:0]  distance_c_o,
  output logic [DistW-1:0]  distance_d_o
);

  logic  q_push, q_full, q_pop, q_valid;
  beat_t q_beat_in, q_beat_out;

  assign full = q_full;

  lpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_byte_i (rx_byte_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_beat_o  (q_beat_in)
  );

  lpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .beat_i  (q_beat_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .beat_o  (q_beat_out),
    .valid_o (q_valid)
  );

  lpd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_beat_i         (q_beat_out),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .start_angle_o    (start_angle_o),
    .rotation_speed_o (rotation_speed_o),
    .distance_a_o     (distance_a_o),
    .distance_b_o     (distance_b_o),
    .distance_c_o     (distance_c_o),
    .distance_d_o     (distance_d_o)
  );

endmodule

>>> hdl/lpd_front.sv
`timescale 1ns / 1ps

module lpd_front import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output beat_t            q_beat_o
);

  logic            awaiting_q, awaiting_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            accept;

  assign accept = push_i && !q_full_i;

  always_comb begin
    awaiting_d    = awaiting_q;
    pos_d         = pos_q;
    q_push_o      = 1'b0;
    q_beat_o.data = rx_byte_i;
    q_beat_o.pos  = pos_q;
    if (accept) begin
      if (awaiting_q) begin
        if (rx_byte_i == HeaderByte) begin
          q_push_o     = 1'b1;
          q_beat_o.pos = PosHeader;
          awaiting_d   = 1'b0;
          pos_d        = PosIndex;
        end
      end else begin
        q_push_o = 1'b1;
        if (pos_q == PosLast) begin
          awaiting_d = 1'b1;
          pos_d      = PosHeader;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      pos_q      <= PosHeader;
    end else begin
      awaiting_q <= awaiting_d;
      pos_q      <= pos_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("packet position out of range");

  a_push_framed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (!awaiting_q || rx_byte_i == HeaderByte))
    else $error("beat queued outside a packet");

endmodule

>>> hdl/lpd_queue.sv
`timescale 1ns / 1ps

module lpd_queue import lpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  beat_t beat_i,
  output logic  full_o,
  input  logic  pop_i,
  output beat_t beat_o,
  output logic  valid_o
);

  beat_t                mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign beat_o  = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count overflow");

endmodule

>>> hdl/lpd_back.sv
`timescale 1ns / 1ps

module lpd_back import lpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  beat_t             q_beat_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [AngleW-1:0] start_angle_o,
  output logic [SpeedW-1:0] rotation_speed_o,
  output logic [DistW-1:0]  distance_a_o,
  output logic [DistW-1:0]  distance_b_o,
  output logic [DistW-1:0]  distance_c_o,
  output logic [DistW-1:0]  distance_d_o
);

  // fields captured from the packet in flight
  logic [ByteW-1:0]  index_q;
  logic [SpeedW-1:0] speed_q;
  logic [DistW-1:0]  dist_a_q, dist_b_q, dist_c_q, dist_d_q;

  // result slot
  logic              res_valid_q, res_valid_d;
  logic [AngleW-1:0] res_angle_q;
  logic [SpeedW-1:0] res_speed_q;
  logic [DistW-1:0]  res_a_q, res_b_q, res_c_q, res_d_q;

  logic              is_last, take, out_pop;
  logic [AngleW-1:0] angle_diff;

  assign is_last    = (q_beat_i.pos == PosLast);
  assign out_pop    = pop_i && res_valid_q;
  assign take       = q_valid_i && (!is_last || !res_valid_q || out_pop);
  assign q_pop_o    = take;
  assign angle_diff = {{(AngleW-ByteW){1'b0}}, index_q} - {{(AngleW-ByteW){1'b0}}, AngleBase};

  always_comb begin
    res_valid_d = res_valid_q;
    if (take && is_last) begin
      res_valid_d = 1'b1;
    end else if (out_pop) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      case (q_beat_i.pos)
        PosIndex:   index_q              <= q_beat_i.data;
        PosSpeedLo: speed_q[ByteW-1:0]   <= q_beat_i.data;
        PosSpeedHi: speed_q[SpeedW-1:ByteW] <= q_beat_i.data;
        PosDistALo: dist_a_q[ByteW-1:0]  <= q_beat_i.data;
        PosDistAHi: dist_a_q[DistW-1:ByteW] <= q_beat_i.data[DistHighW-1:0];
        PosDistBLo: dist_b_q[ByteW-1:0]  <= q_beat_i.data;
        PosDistBHi: dist_b_q[DistW-1:ByteW] <= q_beat_i.data[DistHighW-1:0];
        PosDistCLo: dist_c_q[ByteW-1:0]  <= q_beat_i.data;
        PosDistCHi: dist_c_q[DistW-1:ByteW] <= q_beat_i.data[DistHighW-1:0];
        PosDistDLo: dist_d_q[ByteW-1:0]  <= q_beat_i.data;
        PosDistDHi: dist_d_q[DistW-1:ByteW] <= q_beat_i.data[DistHighW-1:0];
        default: ;
      endcase
      if (is_last) begin
        res_angle_q <= {angle_diff[AngleW-3:0], 2'b00};
        res_speed_q <= speed_q;
        res_a_q     <= dist_a_q;
        res_b_q     <= dist_b_q;
        res_c_q     <= dist_c_q;
        res_d_q     <= dist_d_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  assign empty_o          = !res_valid_q;
  assign start_angle_o    = res_angle_q;
  assign rotation_speed_o = res_speed_q;
  assign distance_a_o     = res_a_q;
  assign distance_b_o     = res_b_q;
  assign distance_c_o     = res_c_q;
  assign distance_d_o     = res_d_q;

  a_last_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_last) |=> res_valid_q)
    else $error("last beat taken without result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_last) |-> (!res_valid_q || out_pop))
    else $error("result slot overwritten");

endmodule
